// ===== hw/rtl/sbbd_pkg.sv =====
// Shared types and constants for the semaphore bounded-buffer dispatcher.
// No dependencies; every other file in hw/rtl refers to this package.
package sbbd_pkg;

    localparam int BUFFER_SLOTS_DEF = 5;
    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int ID_BITS_DEF      = 16;

    localparam int PID_W   = 16;
    localparam int CHAR_W  = 8;
    localparam int LEVEL_W = 6;

    // command codes (only bit 1 separates add from dispatch)
    localparam logic [1:0] CMD_ADD_PROD = 2'd0;
    localparam logic [1:0] CMD_ADD_CONS = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    // outcome codes
    localparam logic [2:0] OUT_QUEUED   = 3'd0;
    localparam logic [2:0] OUT_STORED   = 3'd1;
    localparam logic [2:0] OUT_TAKEN    = 3'd2;
    localparam logic [2:0] OUT_PROD_BLK = 3'd3;
    localparam logic [2:0] OUT_CONS_BLK = 3'd4;
    localparam logic [2:0] OUT_NONE     = 3'd5;
    localparam logic [2:0] OUT_REJECT   = 3'd6;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAR_W-1:0] product_char;
    } t_req;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [PID_W-1:0]   process_id;
        logic               is_producer;
        logic [CHAR_W-1:0]  item_char;
        logic               woke_valid;
        logic [PID_W-1:0]   woke_id;
        logic [LEVEL_W-1:0] buffer_level;
        logic               ready_empty;
        logic               producers_waiting;
        logic               consumers_waiting;
    } t_rsp;

    // memory access strobes: rd loads the read register, pop/push commit
    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } t_mem_ctl;

    typedef struct packed {
        logic full;
        logic empty;
        logic empty_n;  // empty once this cycle's pop/push commit
    } t_q_sts;

    typedef struct packed {
        logic full;
        logic empty;
    } t_stk_sts;

endpackage

// ===== hw/rtl/sbbd_queue.sv =====
// Circular FIFO held in a synchronous memory with a registered head read.
// Depends on sbbd_pkg for the control and status structs.
module sbbd_queue #(
    parameter int DEPTH = sbbd_pkg::QUEUE_DEPTH_DEF,
    parameter int W     = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbbd_pkg::t_mem_ctl  i_ctl,
    input  logic [W-1:0]        i_wdata,
    output logic [W-1:0]        o_rdata,
    output sbbd_pkg::t_q_sts    o_sts
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [W-1:0]  r_rdata;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        n_cnt = r_cnt + CW'(i_ctl.push) - CW'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata       = r_rdata;
    assign o_sts.full    = (r_cnt == CW'(DEPTH));
    assign o_sts.empty   = (r_cnt == '0);
    assign o_sts.empty_n = (n_cnt == '0);

endmodule

// ===== hw/rtl/sbbd_stack.sv =====
// Last-in-first-out character buffer with a fill level and registered top read.
// Depends on sbbd_pkg for the control and status structs.
module sbbd_stack #(
    parameter int SLOTS = sbbd_pkg::BUFFER_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbbd_pkg::t_mem_ctl          i_ctl,
    input  logic [sbbd_pkg::CHAR_W-1:0] i_wchar,
    output logic [sbbd_pkg::CHAR_W-1:0] o_top,
    output sbbd_pkg::t_stk_sts          o_sts,
    output logic [sbbd_pkg::LEVEL_W-1:0] o_level_n
);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int BW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [sbbd_pkg::CHAR_W-1:0] r_mem [SLOTS];
    logic [sbbd_pkg::CHAR_W-1:0] r_top;
    logic [LW-1:0]               r_level, n_level;

    assign n_level = r_level + LW'(i_ctl.push) - LW'(i_ctl.pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    // read the top slot only when one exists
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[BW'(r_level)] <= i_wchar;
        end
        if (i_ctl.rd && (r_level != '0)) begin
            r_top <= r_mem[BW'(r_level - 1'b1)];
        end
    end

    assign o_top      = r_top;
    assign o_sts.full  = (r_level == LW'(SLOTS));
    assign o_sts.empty = (r_level == '0);
    assign o_level_n   = sbbd_pkg::LEVEL_W'(n_level);

endmodule

// ===== hw/rtl/semaphore_bounded_buffer_dispatcher_top.sv =====
// Top level of the semaphore bounded-buffer dispatcher: request decode, queue
// and buffer control, response register. Uses sbbd_pkg, sbbd_queue, sbbd_stack.
//
//  channel   direction  valid         ready         payload
//  request   in         i_req_valid   o_req_ready   i_req  (sbbd_pkg::t_req)
//  response  out        o_rsp_valid   i_rsp_ready   o_rsp  (sbbd_pkg::t_rsp)
//
// A request has an accept cycle and a commit cycle: the accept cycle reads the
// ready-queue head, both wait-queue heads and the buffer top from their synchronous
// memories; the commit cycle decides, writes back and loads the response register.
// A request is accepted only in the idle state, one at a time.
// The commit cycle waits while a previous response is still held unread.
// Synchronous reset clears pointers, counts, fill level and the id counter;
// memory contents are not cleared and need no clearing pass.
module semaphore_bounded_buffer_dispatcher_top #(
    parameter int BUFFER_SLOTS = sbbd_pkg::BUFFER_SLOTS_DEF,
    parameter int QUEUE_DEPTH  = sbbd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS      = sbbd_pkg::ID_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  sbbd_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output sbbd_pkg::t_rsp o_rsp
);
    localparam int PW = sbbd_pkg::PID_W;
    localparam int CHW = sbbd_pkg::CHAR_W;
    localparam int IW = (ID_BITS < PW) ? ID_BITS : PW;
    // ready entry: {producer, char, id}; producer wait: {char, id}; consumer: id
    localparam int RW = IW + CHW + 1;
    localparam int PWW = IW + CHW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                r_state, n_state;
    logic                r_disp;
    logic                r_prod;
    logic [CHW-1:0]      r_pchar;
    logic [ID_BITS-1:0]  r_next_id;
    logic                r_rsp_valid;
    sbbd_pkg::t_rsp      r_rsp, n_rsp;

    sbbd_pkg::t_mem_ctl  rq_ctl, pw_ctl, cw_ctl, stk_ctl;
    sbbd_pkg::t_q_sts    rq_sts, pw_sts, cw_sts;
    sbbd_pkg::t_stk_sts  stk_sts;
    logic [RW-1:0]       rq_rdata, rq_wdata;
    logic [PWW-1:0]      pw_rdata, pw_wdata;
    logic [IW-1:0]       cw_rdata, cw_wdata;
    logic [CHW-1:0]      stk_top, stk_wchar;
    logic [sbbd_pkg::LEVEL_W-1:0] stk_level_n;

    logic                accept;
    logic                commit;
    logic [ID_BITS-1:0]  id_inc;
    logic                bump_id;
    logic                e_prod;
    logic [CHW-1:0]      e_ch;
    logic [IW-1:0]       e_id;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign commit      = (r_state == ST_EXEC) && (!r_rsp_valid || i_rsp_ready);
    assign id_inc      = r_next_id + 1'b1;

    assign e_prod = rq_rdata[RW-1];
    assign e_ch   = rq_rdata[IW +: CHW];
    assign e_id   = rq_rdata[IW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: if (commit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        rq_ctl      = '0;
        pw_ctl      = '0;
        cw_ctl      = '0;
        stk_ctl     = '0;
        rq_wdata    = '0;
        pw_wdata    = {e_ch, e_id};
        cw_wdata    = e_id;
        stk_wchar   = e_ch;
        bump_id     = 1'b0;
        n_rsp       = '0;

        // fetch all heads on accept; the decision in the commit cycle needs them
        rq_ctl.rd  = accept;
        pw_ctl.rd  = accept;
        cw_ctl.rd  = accept;
        stk_ctl.rd = accept;

        if (!r_disp) begin
            if (rq_sts.full) begin
                n_rsp.outcome = sbbd_pkg::OUT_REJECT;
            end else begin
                bump_id            = commit;
                rq_ctl.push        = commit;
                rq_wdata           = {r_prod, r_prod ? r_pchar : '0, IW'(id_inc)};
                n_rsp.outcome      = sbbd_pkg::OUT_QUEUED;
                n_rsp.process_id   = PW'(IW'(id_inc));
                n_rsp.is_producer  = r_prod;
            end
        end else if (rq_sts.empty) begin
            n_rsp.outcome = sbbd_pkg::OUT_NONE;
        end else begin
            rq_ctl.pop        = commit;
            n_rsp.process_id  = PW'(e_id);
            n_rsp.is_producer = e_prod;
            if (e_prod) begin
                if (!stk_sts.full) begin
                    stk_ctl.push    = commit;
                    n_rsp.outcome   = sbbd_pkg::OUT_STORED;
                    n_rsp.item_char = e_ch;
                    if (!cw_sts.empty) begin
                        cw_ctl.pop       = commit;
                        rq_ctl.push      = commit;
                        rq_wdata         = {1'b0, {CHW{1'b0}}, cw_rdata};
                        n_rsp.woke_valid = 1'b1;
                        n_rsp.woke_id    = PW'(cw_rdata);
                    end
                end else if (pw_sts.full) begin
                    n_rsp.outcome = sbbd_pkg::OUT_REJECT;
                end else begin
                    pw_ctl.push   = commit;
                    n_rsp.outcome = sbbd_pkg::OUT_PROD_BLK;
                end
            end else begin
                if (!stk_sts.empty) begin
                    stk_ctl.pop     = commit;
                    n_rsp.outcome   = sbbd_pkg::OUT_TAKEN;
                    n_rsp.item_char = stk_top;
                    if (!pw_sts.empty) begin
                        pw_ctl.pop       = commit;
                        rq_ctl.push      = commit;
                        rq_wdata         = {1'b1, pw_rdata};
                        n_rsp.woke_valid = 1'b1;
                        n_rsp.woke_id    = PW'(pw_rdata[IW-1:0]);
                    end
                end else if (cw_sts.full) begin
                    n_rsp.outcome = sbbd_pkg::OUT_REJECT;
                end else begin
                    cw_ctl.push   = commit;
                    n_rsp.outcome = sbbd_pkg::OUT_CONS_BLK;
                end
            end
        end

        n_rsp.buffer_level      = stk_level_n;
        n_rsp.ready_empty       = rq_sts.empty_n;
        n_rsp.producers_waiting = !pw_sts.empty_n;
        n_rsp.consumers_waiting = !cw_sts.empty_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_id   <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (bump_id) begin
                r_next_id <= id_inc;
            end
            if (commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // hold the decoded request for the commit cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_disp  <= i_req.command[1];
            r_prod  <= (i_req.command == sbbd_pkg::CMD_ADD_PROD);
            r_pchar <= i_req.product_char;
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    sbbd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (RW)
    ) u_ready_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rq_ctl),
        .i_wdata (rq_wdata),
        .o_rdata (rq_rdata),
        .o_sts   (rq_sts)
    );

    sbbd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (PWW)
    ) u_prod_wait_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pw_ctl),
        .i_wdata (pw_wdata),
        .o_rdata (pw_rdata),
        .o_sts   (pw_sts)
    );

    sbbd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (IW)
    ) u_cons_wait_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cw_ctl),
        .i_wdata (cw_wdata),
        .o_rdata (cw_rdata),
        .o_sts   (cw_sts)
    );

    sbbd_stack #(
        .SLOTS (BUFFER_SLOTS)
    ) u_char_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (stk_ctl),
        .i_wchar   (stk_wchar),
        .o_top     (stk_top),
        .o_sts     (stk_sts),
        .o_level_n (stk_level_n)
    );

endmodule
